FILE: hw/rtl/polygon_point_distance_range_top_assert.svh
// assertion macros for the polygon point distance range block
`ifndef POLYGON_POINT_DISTANCE_RANGE_TOP_ASSERT_SVH
`define POLYGON_POINT_DISTANCE_RANGE_TOP_ASSERT_SVH

// consequence must hold in the same cycle as the condition
`define PPDR_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// consequence must hold in the cycle after the condition
`define PPDR_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/ppdr_pkg.sv
// shared types and constants of the polygon point distance range block
package ppdr_pkg;

   localparam int CoordBits = 21;
   localparam int FracBits  = 16;
   localparam int MaxW      = 2 * CoordBits + 2;
   localparam int MinW      = MaxW + FracBits;
   localparam int AreaW     = MinW + 1;
   localparam int CsrIdxW   = 4;

   typedef logic signed [CoordBits-1:0] coord_type;
   typedef logic [MaxW-1:0]             max_type;
   typedef logic [MinW-1:0]             min_type;
   typedef logic [AreaW-1:0]            area_type;
   typedef logic [CsrIdxW-1:0]          csr_idx_type;

   localparam csr_idx_type RegCenterX = csr_idx_type'(0);
   localparam csr_idx_type RegCenterY = csr_idx_type'(1);

endpackage

FILE: hw/rtl/ppdr_if.sv
// request, response and register write channels of the block
interface ppdr_req_if import ppdr_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type vertex_x;
   coord_type vertex_y;
   logic      last_vertex;
   modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
   modport sink (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface ppdr_rsp_if import ppdr_pkg::*; ();
   logic     valid;
   logic     ready;
   max_type  max_sq_dist;
   min_type  min_sq_dist;
   area_type ring_area;
   modport source (output valid, max_sq_dist, min_sq_dist, ring_area, input ready);
   modport sink (input valid, max_sq_dist, min_sq_dist, ring_area, output ready);
endinterface

interface ppdr_csr_if import ppdr_pkg::*; ();
   logic        valid;
   logic        ready;
   csr_idx_type index;
   coord_type   data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/polygon_point_distance_range_top.sv
// each vertex measures the edge from the previous one; a division runs only when the foot lies inside it
// the final vertex also runs the closing edge and the area
// the work is done by the 60-step restoring divider and the shared 34x34 multiplier,
// which handles each product as a multiply, then an accumulate
// one vertex at a time; request ready only while idle
// synchronous active-high reset: empty polygon, center at origin, no response pending
`include "polygon_point_distance_range_top_assert.svh"

module polygon_point_distance_range_top import ppdr_pkg::*; (
   input logic         clock,
   input logic         reset,
   ppdr_req_if.sink    req_chan,
   ppdr_rsp_if.source  rsp_chan,
   ppdr_csr_if.sink    csr_chan
);

   localparam int DiffW    = CoordBits + 1;
   localparam int MulW     = 34;
   localparam int ProdW    = 2 * MulW;
   localparam int AccW     = 98;
   localparam int DotW     = 2 * DiffW + 2;
   localparam int DistW    = 2 * DiffW - 1;
   localparam int CrW      = 2 * DiffW + 1;
   localparam int LenW     = MaxW;
   localparam int DivSteps = MinW;
   localparam int DivCntW  = $clog2(DivSteps);
   localparam int StepW    = 5;
   localparam logic [MulW-1:0] PiQ32 = 34'h3_243F_6A89;

   localparam logic [StepW-1:0] StepT     = StepW'(1);
   localparam logic [StepW-1:0] StepL     = StepW'(3);
   localparam logic [StepW-1:0] StepDa    = StepW'(5);
   localparam logic [StepW-1:0] StepDb    = StepW'(7);
   localparam logic [StepW-1:0] StepCr    = StepW'(9);
   localparam logic [StepW-1:0] StepSq0   = StepW'(10);
   localparam logic [StepW-1:0] StepSqEnd = StepW'(12);
   localparam logic [StepW-1:0] StepArea0 = StepW'(13);
   localparam logic [StepW-1:0] StepLast  = StepW'(16);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SETUP, ST_MUL, ST_ACC, ST_DECIDE, ST_DIV, ST_MIN, ST_AREA, ST_RESULT
   } state_type;
   typedef enum logic {PH_VERTEX, PH_CLOSE} phase_type;
   typedef enum logic [3:0] {
      OP_UX, OP_UY, OP_EX, OP_EY, OP_WX, OP_WY, OP_CH, OP_CL, OP_DH, OP_DL, OP_PH, OP_PL
   } opnd_type;
   typedef enum logic [1:0] {SH_0, SH_32, SH_33, SH_64} shift_type;
   typedef enum logic [1:0] {AC_LOAD, AC_ADD, AC_SUB} accop_type;
   typedef struct packed {
      opnd_type  a;
      opnd_type  b;
      shift_type sh;
      accop_type op;
   } uop_type;

   state_type  state_ff;
   phase_type  phase_ff;
   logic [StepW-1:0] step_ff;

   // configuration
   coord_type center_x_ff, center_y_ff;

   // captured request and polygon state
   coord_type vx_ff, vy_ff;
   logic      last_ff;
   coord_type first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic      have_first_ff;
   max_type   run_max_ff;
   min_type   run_min_ff;

   // edge operands and results
   logic signed [DiffW-1:0] ux_ff, uy_ff, ex_ff, ey_ff, wx_ff, wy_ff;
   logic signed [DotW-1:0]  t_ff;
   logic [LenW-1:0]         len_ff;
   logic [DistW-1:0]        da_ff, db_ff;
   logic [CrW-1:0]          cr_mag_ff;
   min_type                 edge_d_ff;
   min_type                 diff_ff;

   // shared multiply-accumulate unit
   logic signed [ProdW-1:0] prod_ff;
   logic signed [AccW-1:0]  acc_ff;

   // divider
   logic [LenW-1:0]    rem_ff;
   min_type            div_n_ff;
   logic [DivCntW-1:0] div_cnt_ff;

   // response register
   logic     rsp_valid_ff;
   max_type  rsp_max_ff;
   min_type  rsp_min_ff;
   area_type rsp_area_ff;

   uop_type                 uop;
   logic signed [MulW-1:0]  mul_a, mul_b;
   logic signed [ProdW-1:0] mul_full;
   logic signed [AccW-1:0]  prod_ext, prod_sh, acc_in;
   logic [LenW:0]           div_r2;
   logic                    div_ge;
   logic [LenW-1:0]         div_rem_in;
   coord_type               ax, ay, bx, by;
   logic signed [DiffW-1:0] cx_ext, cy_ext;
   logic signed [CrW-1:0]   cr_val;
   min_type                 maxf;
   logic [AccW-33:0]        area_full;
   area_type                area_sat;
   logic                    rsp_load;

   // micro-program of the shared unit
   always_comb begin
      case (step_ff)
         5'd0:    uop = '{OP_UX, OP_EX, SH_0, AC_LOAD};
         5'd1:    uop = '{OP_UY, OP_EY, SH_0, AC_ADD};   // t = u.e
         5'd2:    uop = '{OP_EX, OP_EX, SH_0, AC_LOAD};
         5'd3:    uop = '{OP_EY, OP_EY, SH_0, AC_ADD};   // squared edge length
         5'd4:    uop = '{OP_UX, OP_UX, SH_0, AC_LOAD};
         5'd5:    uop = '{OP_UY, OP_UY, SH_0, AC_ADD};   // squared distance to start point
         5'd6:    uop = '{OP_WX, OP_WX, SH_0, AC_LOAD};
         5'd7:    uop = '{OP_WY, OP_WY, SH_0, AC_ADD};   // squared distance to end point
         5'd8:    uop = '{OP_UX, OP_EY, SH_0, AC_LOAD};
         5'd9:    uop = '{OP_UY, OP_EX, SH_0, AC_SUB};   // cross product
         5'd10:   uop = '{OP_CH, OP_CH, SH_64, AC_LOAD}; // cross squared, hi*hi
         5'd11:   uop = '{OP_CH, OP_CL, SH_33, AC_ADD};  // twice hi*lo
         5'd12:   uop = '{OP_CL, OP_CL, SH_0, AC_ADD};
         5'd13:   uop = '{OP_DL, OP_PL, SH_0, AC_LOAD};  // area = diff * pi
         5'd14:   uop = '{OP_DL, OP_PH, SH_32, AC_ADD};
         5'd15:   uop = '{OP_DH, OP_PL, SH_32, AC_ADD};
         5'd16:   uop = '{OP_DH, OP_PH, SH_64, AC_ADD};
         default: uop = '{OP_UX, OP_UX, SH_0, AC_LOAD};
      endcase
   end

   function automatic logic signed [MulW-1:0] pick(input opnd_type s);
      case (s)
         OP_UX:   pick = MulW'(ux_ff);
         OP_UY:   pick = MulW'(uy_ff);
         OP_EX:   pick = MulW'(ex_ff);
         OP_EY:   pick = MulW'(ey_ff);
         OP_WX:   pick = MulW'(wx_ff);
         OP_WY:   pick = MulW'(wy_ff);
         OP_CH:   pick = $signed(MulW'(cr_mag_ff[CrW-1:32]));
         OP_CL:   pick = $signed(MulW'(cr_mag_ff[31:0]));
         OP_DH:   pick = $signed(MulW'(diff_ff[MinW-1:32]));
         OP_DL:   pick = $signed(MulW'(diff_ff[31:0]));
         OP_PH:   pick = $signed(MulW'(PiQ32[MulW-1:32]));
         OP_PL:   pick = $signed(MulW'(PiQ32[31:0]));
         default: pick = '0;
      endcase
   endfunction

   always_comb begin
      mul_a    = pick(uop.a);
      mul_b    = pick(uop.b);
      mul_full = mul_a * mul_b;
      prod_ext = AccW'(prod_ff);
      case (uop.sh)
         SH_0:    prod_sh = prod_ext;
         SH_32:   prod_sh = prod_ext <<< 32;
         SH_33:   prod_sh = prod_ext <<< 33;
         SH_64:   prod_sh = prod_ext <<< 64;
         default: prod_sh = prod_ext;
      endcase
      case (uop.op)
         AC_LOAD: acc_in = prod_sh;
         AC_ADD:  acc_in = acc_ff + prod_sh;
         AC_SUB:  acc_in = acc_ff - prod_sh;
         default: acc_in = prod_sh;
      endcase
      cr_val = acc_in[CrW-1:0];
   end

   // one restoring division step, remainder always below the edge length
   always_comb begin
      div_r2     = {rem_ff, div_n_ff[MinW-1]};
      div_ge     = div_r2 >= {1'b0, len_ff};
      div_rem_in = div_ge ? LenW'(div_r2 - {1'b0, len_ff}) : div_r2[LenW-1:0];
   end

   // edge endpoints: first vertex measures against itself, closing edge returns to first
   always_comb begin
      if (phase_ff == PH_CLOSE) begin
         ax = vx_ff;      ay = vy_ff;
         bx = first_x_ff; by = first_y_ff;
      end else begin
         ax = have_first_ff ? prev_x_ff : vx_ff;
         ay = have_first_ff ? prev_y_ff : vy_ff;
         bx = vx_ff;      by = vy_ff;
      end
      cx_ext = DiffW'(center_x_ff);
      cy_ext = DiffW'(center_y_ff);
   end

   always_comb begin
      maxf      = {run_max_ff, FracBits'(0)};
      area_full = acc_ff[AccW-1:32];
      area_sat  = (area_full > (AccW-32)'({AreaW{1'b1}})) ? '1 : area_full[AreaW-1:0];
      rsp_load  = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_VERTEX;
         step_ff       <= '0;
         div_cnt_ff    <= '0;
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         have_first_ff <= 1'b0;
         run_max_ff    <= '0;
         run_min_ff    <= '1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            case (csr_chan.index)
               RegCenterX: center_x_ff <= csr_chan.data;
               RegCenterY: center_y_ff <= csr_chan.data;
               default: ;
            endcase
         end
         // a new response loaded in the same cycle keeps valid high
         if (rsp_valid_ff && rsp_chan.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  vx_ff    <= req_chan.vertex_x;
                  vy_ff    <= req_chan.vertex_y;
                  last_ff  <= req_chan.last_vertex;
                  phase_ff <= PH_VERTEX;
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               ux_ff    <= cx_ext - DiffW'(ax);
               uy_ff    <= cy_ext - DiffW'(ay);
               ex_ff    <= DiffW'(bx) - DiffW'(ax);
               ey_ff    <= DiffW'(by) - DiffW'(ay);
               wx_ff    <= cx_ext - DiffW'(bx);
               wy_ff    <= cy_ext - DiffW'(by);
               step_ff  <= '0;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               prod_ff  <= mul_full;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               acc_ff <= acc_in;
               case (step_ff)
                  StepT:  t_ff   <= acc_in[DotW-1:0];
                  StepL:  len_ff <= acc_in[LenW-1:0];
                  StepDa: da_ff  <= acc_in[DistW-1:0];
                  StepDb: db_ff  <= acc_in[DistW-1:0];
                  StepCr: cr_mag_ff <= cr_val[CrW-1] ? CrW'(-cr_val) : cr_val;
                  default: ;
               endcase
               if (step_ff == StepCr) begin
                  state_ff <= ST_DECIDE;
               end else if (step_ff == StepSqEnd) begin
                  // quotient fits the min field, so the top bits start as remainder
                  rem_ff     <= acc_in[LenW+MinW-FracBits-1:MinW-FracBits];
                  div_n_ff   <= {acc_in[MinW-FracBits-1:0], FracBits'(0)};
                  div_cnt_ff <= '0;
                  state_ff   <= ST_DIV;
               end else if (step_ff == StepLast) begin
                  state_ff <= ST_RESULT;
               end else begin
                  step_ff  <= step_ff + 1'b1;
                  state_ff <= ST_MUL;
               end
            end
            ST_DECIDE: begin
               // projection clamp: foot before start, past end, or inside the segment
               if (t_ff <= 0) begin
                  edge_d_ff <= {MinW'(da_ff)} << FracBits;
                  state_ff  <= ST_MIN;
               end else if (t_ff >= $signed({2'b00, len_ff})) begin
                  edge_d_ff <= {MinW'(db_ff)} << FracBits;
                  state_ff  <= ST_MIN;
               end else begin
                  step_ff  <= StepSq0;
                  state_ff <= ST_MUL;
               end
            end
            ST_DIV: begin
               rem_ff     <= div_rem_in;
               div_n_ff   <= {div_n_ff[MinW-2:0], div_ge};
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == DivCntW'(DivSteps - 1)) begin
                  edge_d_ff <= {div_n_ff[MinW-2:0], div_ge};
                  state_ff  <= ST_MIN;
               end
            end
            ST_MIN: begin
               if (phase_ff == PH_CLOSE) begin
                  if (edge_d_ff < run_min_ff) run_min_ff <= edge_d_ff;
                  state_ff <= ST_AREA;
               end else begin
                  if (have_first_ff && (edge_d_ff < run_min_ff)) run_min_ff <= edge_d_ff;
                  if (MaxW'(db_ff) > run_max_ff) run_max_ff <= MaxW'(db_ff);
                  prev_x_ff <= vx_ff;
                  prev_y_ff <= vy_ff;
                  if (!have_first_ff) begin
                     first_x_ff    <= vx_ff;
                     first_y_ff    <= vy_ff;
                     have_first_ff <= 1'b1;
                  end
                  if (last_ff) begin
                     phase_ff <= PH_CLOSE;
                     state_ff <= ST_SETUP;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_AREA: begin
               diff_ff  <= (maxf > run_min_ff) ? maxf - run_min_ff : '0;
               step_ff  <= StepArea0;
               state_ff <= ST_MUL;
            end
            ST_RESULT: begin
               if (rsp_load) begin
                  rsp_max_ff    <= run_max_ff;
                  rsp_min_ff    <= run_min_ff;
                  rsp_area_ff   <= area_sat;
                  rsp_valid_ff  <= 1'b1;
                  have_first_ff <= 1'b0;
                  run_max_ff    <= '0;
                  run_min_ff    <= '1;
                  phase_ff      <= PH_VERTEX;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // ports
   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.max_sq_dist = rsp_max_ff;
   assign rsp_chan.min_sq_dist = rsp_min_ff;
   assign rsp_chan.ring_area   = rsp_area_ff;

   `PPDR_ASSERT_NEXT(a_request_starts_setup, clock, reset, req_chan.valid && req_chan.ready, state_ff == ST_SETUP, "accepted request did not start edge setup")
   `PPDR_ASSERT_NOW(a_div_rem_below_len, clock, reset, state_ff == ST_DIV, rem_ff < len_ff, "divider remainder not below edge length")
   `PPDR_ASSERT_NOW(a_div_count_range, clock, reset, state_ff == ST_DIV, div_cnt_ff <= DivCntW'(DivSteps - 1), "divider ran past its step count")
   `PPDR_ASSERT_NEXT(a_result_restarts_polygon, clock, reset, rsp_load, rsp_valid_ff && !have_first_ff && (run_max_ff == '0), "response load did not restart the polygon")

endmodule
